>>> rtl/plla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plla_pkg
// Shared types and constants of the lookahead point selector.
// ----------------------------------------------------------------------------
package plla_pkg;

  localparam int CFG_W   = 23;           // width of the radius and time registers
  localparam int TB      = 24;           // fraction bits of the segment parameter t
  localparam int TW      = TB + 1;       // t runs from 0 to 2^TB inclusive
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W-1:0] FIXED_RST = CFG_W'(19661);
  localparam logic [CFG_W-1:0] SECS_RST  = CFG_W'(65536);
  localparam logic [CFG_W-1:0] MIN_RST   = CFG_W'(13107);
  localparam logic [CFG_W-1:0] MAX_RST   = CFG_W'(65536);

  typedef enum logic [2:0] {
    REG_USE_INTERP   = 3'd0,
    REG_USE_SPEED    = 3'd1,
    REG_FIXED        = 3'd2,
    REG_SECONDS      = 3'd3,
    REG_MIN          = 3'd4,
    REG_MAX          = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CROSS  = 2'd0,
    KIND_INTERP = 2'd1,
    KIND_LAST   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    MUL_SX2, MUL_SY2, MUL_SCALE, MUL_R2, MUL_X2, MUL_Y2,
    MUL_DXM, MUL_DYM, MUL_CX2, MUL_CY2
  } mul_sel_t;

  typedef struct packed {
    logic             use_interp;
    logic             use_speed;
    logic [CFG_W-1:0] fixed_r;
    logic [CFG_W-1:0] secs;
    logic [CFG_W-1:0] rmin;
    logic [CFG_W-1:0] rmax;
  } cfg_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     cap_in;
    logic     acc_load;
    logic     acc_add;
    logic     sq_init;
    logic     sq_step;
    logic     rad_load;
    logic     r2_load;
    logic     x_init;
    logic     mid_load;
    logic     candx_load;
    logic     candy_load;
    logic     bis_upd;
    logic     prev_load;
    logic     out_load;
    kind_t    kind;
  } dp_cmd_t;

  typedef struct packed {
    logic sq_last;
    logic ge;
    logic gap_gt1;
  } dp_sts_t;

endpackage

>>> rtl/plla_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plla_cfg
// APB register file holding the lookahead settings.
// ----------------------------------------------------------------------------
module plla_cfg import plla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_interp <= 1'b1;
      cfg_r.use_speed  <= 1'b1;
      cfg_r.fixed_r    <= FIXED_RST;
      cfg_r.secs       <= SECS_RST;
      cfg_r.rmin       <= MIN_RST;
      cfg_r.rmax       <= MAX_RST;
    end else if (wr) begin
      case (idx)
        REG_USE_INTERP: cfg_r.use_interp <= pwdata[0];
        REG_USE_SPEED:  cfg_r.use_speed  <= pwdata[0];
        REG_FIXED:      cfg_r.fixed_r    <= pwdata[CFG_W-1:0];
        REG_SECONDS:    cfg_r.secs       <= pwdata[CFG_W-1:0];
        REG_MIN:        cfg_r.rmin       <= pwdata[CFG_W-1:0];
        REG_MAX:        cfg_r.rmax       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_USE_INTERP: prdata = DATA_W'(cfg_r.use_interp);
      REG_USE_SPEED:  prdata = DATA_W'(cfg_r.use_speed);
      REG_FIXED:      prdata = DATA_W'(cfg_r.fixed_r);
      REG_SECONDS:    prdata = DATA_W'(cfg_r.secs);
      REG_MIN:        prdata = DATA_W'(cfg_r.rmin);
      REG_MAX:        prdata = DATA_W'(cfg_r.rmax);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/plla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plla_dp
// Datapath: shared multiplier, norm accumulator, bit-serial square root,
// radius latch, bisection registers and result register.
// ----------------------------------------------------------------------------
module plla_dp import plla_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  cfg_t                          cfg,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_speed_x,
  input  logic signed [COORD_WIDTH-1:0] in_speed_y,
  output logic signed [COORD_WIDTH-1:0] out_carrot_x,
  output logic signed [COORD_WIDTH-1:0] out_carrot_y,
  output logic [1:0]                    out_carrot_kind
);

  localparam int W    = COORD_WIDTH;
  localparam int MW   = (W + 1 > TW + 1) ? W + 1 : TW + 1;
  localparam int PW   = 2 * MW;
  localparam int NW   = 2 * W;
  localparam int CMPW = (NW > 2 * CFG_W) ? NW : 2 * CFG_W;
  localparam int SW   = PW - 16;

  logic signed [W-1:0]    x_r, y_r, sx_r, sy_r, prev_x_r, prev_y_r;
  logic signed [W-1:0]    cand_x_r, cand_y_r, res_x_r, res_y_r;
  logic signed [W-1:0]    out_x_r, out_y_r;
  logic [1:0]             out_kind_r;
  logic signed [W:0]      dx_r, dy_r;
  logic signed [PW-1:0]   prod_r;
  logic [NW-1:0]          acc_r, num_r, sqr_r, bit_r;
  logic [CFG_W-1:0]       radius_r;
  logic [2*CFG_W-1:0]     r2_r;
  logic [TW-1:0]          lo_r, hi_r, mid_r;

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [PW-1:0]   mul_out;
  logic signed [PW-1:0]   prod_sh;
  logic signed [W:0]      cand_sum_x, cand_sum_y;
  logic [NW-1:0]          trial;
  logic [SW-1:0]          scaled, lo_clamped, clamped;
  logic [TW-1:0]          gap;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SX2:   begin op_a = MW'(sx_r);           op_b = MW'(sx_r);           end
      MUL_SY2:   begin op_a = MW'(sy_r);           op_b = MW'(sy_r);           end
      MUL_SCALE: begin op_a = MW'(sqr_r[W-1:0]);   op_b = MW'(cfg.secs);       end
      MUL_R2:    begin op_a = MW'(radius_r);       op_b = MW'(radius_r);       end
      MUL_X2:    begin op_a = MW'(x_r);            op_b = MW'(x_r);            end
      MUL_Y2:    begin op_a = MW'(y_r);            op_b = MW'(y_r);            end
      MUL_DXM:   begin op_a = MW'(dx_r);           op_b = MW'(mid_r);          end
      MUL_DYM:   begin op_a = MW'(dy_r);           op_b = MW'(mid_r);          end
      MUL_CX2:   begin op_a = MW'(cand_x_r);       op_b = MW'(cand_x_r);       end
      MUL_CY2:   begin op_a = MW'(cand_y_r);       op_b = MW'(cand_y_r);       end
      default:   begin op_a = '0;                  op_b = '0;                  end
    endcase
  end

  assign mul_out = op_a * op_b;

  // floor(d * t / 2^TB) added to the previous point
  assign prod_sh    = prod_r >>> TB;
  assign cand_sum_x = (W+1)'(prev_x_r) + (W+1)'(prod_sh);
  assign cand_sum_y = (W+1)'(prev_y_r) + (W+1)'(prod_sh);

  assign trial = sqr_r + bit_r;

  assign scaled     = prod_r[PW-1:16];
  assign lo_clamped = (scaled < SW'(cfg.rmin)) ? SW'(cfg.rmin) : scaled;
  assign clamped    = (lo_clamped > SW'(cfg.rmax)) ? SW'(cfg.rmax) : lo_clamped;

  assign gap = hi_r - lo_r;

  assign sts.sq_last = bit_r[0];
  assign sts.ge      = CMPW'(acc_r) >= CMPW'(r2_r);
  assign sts.gap_gt1 = gap > TW'(1);

  always_ff @(posedge clk) begin
    prod_r <= mul_out;
    if (cmd.cap_in) begin
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      sx_r    <= in_speed_x;
      sy_r    <= in_speed_y;
      res_x_r <= in_pos_x;
      res_y_r <= in_pos_y;
    end
    if (cmd.acc_load) acc_r <= prod_r[NW-1:0];
    else if (cmd.acc_add) acc_r <= acc_r + prod_r[NW-1:0];
    // one result bit per cycle
    if (cmd.sq_init) begin
      num_r <= acc_r;
      sqr_r <= '0;
      bit_r <= NW'(1) << (NW - 2);
    end else if (cmd.sq_step) begin
      if (num_r >= trial) begin
        num_r <= num_r - trial;
        sqr_r <= (sqr_r >> 1) + bit_r;
      end else begin
        sqr_r <= sqr_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.rad_load) radius_r <= cfg.use_speed ? clamped[CFG_W-1:0] : cfg.fixed_r;
    if (cmd.r2_load) r2_r <= mul_out[2*CFG_W-1:0];
    if (cmd.x_init) begin
      dx_r <= (W+1)'(x_r) - (W+1)'(prev_x_r);
      dy_r <= (W+1)'(y_r) - (W+1)'(prev_y_r);
      lo_r <= '0;
      hi_r <= TW'(1) << TB;
    end
    if (cmd.mid_load) mid_r <= (lo_r + hi_r) >> 1;
    if (cmd.candx_load) cand_x_r <= cand_sum_x[W-1:0];
    if (cmd.candy_load) cand_y_r <= cand_sum_y[W-1:0];
    if (cmd.bis_upd) begin
      if (sts.ge) begin
        hi_r    <= mid_r;
        res_x_r <= cand_x_r;
        res_y_r <= cand_y_r;
      end else begin
        lo_r <= mid_r;
      end
    end
    if (cmd.prev_load) begin
      prev_x_r <= x_r;
      prev_y_r <= y_r;
    end
    if (cmd.out_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_kind_r <= cmd.kind;
    end
  end

  assign out_carrot_x    = out_x_r;
  assign out_carrot_y    = out_y_r;
  assign out_carrot_kind = out_kind_r;

endmodule

>>> rtl/plla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plla_ctrl
// Sequencer: path state, radius latch, distance test, bisection and output
// handshake.
// ----------------------------------------------------------------------------
module plla_ctrl import plla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_first_point,
  input  logic    in_last_point,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_SPD0, S_SPD1, S_SPD2, S_SQI, S_SQ, S_SCL, S_RAD, S_R2,
    S_N0, S_N1, S_N2, S_CMP, S_XLOOP, S_XMX, S_XMY, S_XSX, S_XSY,
    S_XACC, S_XCMP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   at_start_r, at_start_nxt;
  logic   done_r, done_nxt;
  logic   start_r, start_nxt;
  logic   last_r, last_nxt;
  kind_t  kind_r, kind_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   item_start;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign item_start = in_first_point || at_start_r;

  always_comb begin
    state_nxt    = state_r;
    at_start_nxt = at_start_r;
    done_nxt     = done_r;
    start_nxt    = start_r;
    last_nxt     = last_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_X2;
    cmd.kind     = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in   = 1'b1;
          at_start_nxt = in_last_point;
          start_nxt    = item_start;
          last_nxt     = in_last_point;
          if (item_start) begin
            done_nxt  = 1'b0;
            state_nxt = cfg.use_speed ? S_SPD0 : S_RAD;
          end else if (!done_r) begin
            state_nxt = S_N0;
          end
        end
      end
      S_SPD0: begin cmd.mul_sel = MUL_SX2; state_nxt = S_SPD1; end
      S_SPD1: begin cmd.mul_sel = MUL_SY2; cmd.acc_load = 1'b1; state_nxt = S_SPD2; end
      S_SPD2: begin cmd.acc_add = 1'b1; state_nxt = S_SQI; end
      S_SQI:  begin cmd.sq_init = 1'b1; state_nxt = S_SQ; end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = S_SCL;
      end
      S_SCL:  begin cmd.mul_sel = MUL_SCALE; state_nxt = S_RAD; end
      S_RAD:  begin cmd.rad_load = 1'b1; state_nxt = S_R2; end
      S_R2:   begin cmd.mul_sel = MUL_R2; cmd.r2_load = 1'b1; state_nxt = S_N0; end
      S_N0:   begin cmd.mul_sel = MUL_X2; state_nxt = S_N1; end
      S_N1:   begin cmd.mul_sel = MUL_Y2; cmd.acc_load = 1'b1; state_nxt = S_N2; end
      S_N2:   begin cmd.acc_add = 1'b1; state_nxt = S_CMP; end
      S_CMP: begin
        if (sts.ge) begin
          if (cfg.use_interp && !start_r) begin
            cmd.x_init = 1'b1;
            kind_nxt   = KIND_INTERP;
            state_nxt  = S_XLOOP;
          end else begin
            kind_nxt  = KIND_CROSS;
            state_nxt = S_EMIT;
          end
        end else if (last_r) begin
          kind_nxt  = KIND_LAST;
          state_nxt = S_EMIT;
        end else begin
          cmd.prev_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_XLOOP: begin
        if (sts.gap_gt1) begin
          cmd.mid_load = 1'b1;
          state_nxt    = S_XMX;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_XMX: begin cmd.mul_sel = MUL_DXM; state_nxt = S_XMY; end
      S_XMY: begin
        cmd.mul_sel    = MUL_DYM;
        cmd.candx_load = 1'b1;
        state_nxt      = S_XSX;
      end
      S_XSX: begin
        cmd.mul_sel    = MUL_CX2;
        cmd.candy_load = 1'b1;
        state_nxt      = S_XSY;
      end
      S_XSY:  begin cmd.mul_sel = MUL_CY2; cmd.acc_load = 1'b1; state_nxt = S_XACC; end
      S_XACC: begin cmd.acc_add = 1'b1; state_nxt = S_XCMP; end
      S_XCMP: begin cmd.bis_upd = 1'b1; state_nxt = S_XLOOP; end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.prev_load = 1'b1;
          done_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      at_start_r  <= 1'b1;
      done_r      <= 1'b0;
      start_r     <= 1'b0;
      last_r      <= 1'b0;
      kind_r      <= KIND_CROSS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      at_start_r  <= at_start_nxt;
      done_r      <= done_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/pursuit_lookahead_point_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pursuit_lookahead_point_select
// Picks the lookahead point of a path for a pure-pursuit follower.
// ----------------------------------------------------------------------------
// Usage:
//   Path points enter on the in_ channel (valid/ready), one per transaction,
//   with the robot speed sampled on the first point of a path. At most one
//   result per path leaves on the out_ channel (valid/ready): the first point
//   on or beyond the lookahead radius, the circle crossing of the segment
//   into it, or the last point if none qualifies. Settings must be written
//   over the APB port while the block is idle; the block does not enforce it.
// Sequence (one point in flight at a time, set by the shared multiplier):
//   plain point: squared norm and radius test, then the result load.
//   path start: radius latch and square first; a speed-scaled radius is
//   preceded by the speed norm, square root (one square-root bit per cycle)
//   and scaling. interpolated crossing: 24 bisection steps after the test.
// Reset (synchronous, rst_n low) restores register defaults and makes the
//   next point a path start; no result is pending.
// A stalled receiver holds the result in the output register; the block
//   keeps accepting points that produce no result and waits before
//   overwriting a result that was not yet taken.
// ----------------------------------------------------------------------------
module pursuit_lookahead_point_select import plla_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic                          in_first_point,
  input  logic                          in_last_point,
  input  logic signed [COORD_WIDTH-1:0] in_speed_x,
  input  logic signed [COORD_WIDTH-1:0] in_speed_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_carrot_x,
  output logic signed [COORD_WIDTH-1:0] out_carrot_y,
  output logic [1:0]                    out_carrot_kind
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  plla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plla_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_point (in_first_point),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts)
  );

  plla_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk             (clk),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_speed_x      (in_speed_x),
    .in_speed_y      (in_speed_y),
    .out_carrot_x    (out_carrot_x),
    .out_carrot_y    (out_carrot_y),
    .out_carrot_kind (out_carrot_kind)
  );

endmodule

>>> rtl/plla_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plla_chk
// Port-level checks of the lookahead point selector, bound to the top level.
// ----------------------------------------------------------------------------
module plla_chk import plla_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_carrot_x,
  input logic signed [COORD_WIDTH-1:0] out_carrot_y,
  input logic [1:0]                    out_carrot_kind
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_carrot_x)
      && $stable(out_carrot_y) && $stable(out_carrot_kind))
    else $error("result changed while stalled");

  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_carrot_kind == KIND_CROSS || out_carrot_kind == KIND_INTERP
      || out_carrot_kind == KIND_LAST))
    else $error("illegal result kind");

  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind pursuit_lookahead_point_select plla_chk #(.COORD_WIDTH(COORD_WIDTH)) u_plla_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .pready          (pready),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_carrot_x    (out_carrot_x),
  .out_carrot_y    (out_carrot_y),
  .out_carrot_kind (out_carrot_kind)
);
